### rtl/fbpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fbpa_pkg
// Shared types, codes and helpers of the fixed block pool allocator.
// ============================================================================
package fbpa_pkg;

    localparam int IDX_W = 12;
    localparam int BIC_W = 9;
    localparam int CNT_W = 32;
    localparam int LINK_DEPTH = 4096;

    // Raw reset value of the blocks_in_chunk register.
    localparam logic [BIC_W-1:0] BIC_RESET_RAW = 9'd256;

    // Operation codes on the request port.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register index of blocks_in_chunk (byte address bit 2).
    localparam logic REG_BLOCKS_IN_CHUNK = 1'b0;

    typedef enum logic [2:0] {
        ST_LIST_HIT    = 3'd0,
        ST_BUMP        = 3'd1,
        ST_NEW_CHUNK   = 3'd2,
        ST_EXHAUSTED   = 3'd3,
        ST_FREE_DONE   = 3'd4,
        ST_FREE_REJECT = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_FREE
    } t_state;

    // One link memory entry: next block of the free list and an end marker.
    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] next;
    } t_link_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_link_rd;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_link_entry      data;
    } t_link_wr;

    // Configuration seen by the allocator core.
    typedef struct packed {
        logic             reinit;   // register written this cycle
        logic [BIC_W-1:0] bic_next; // clamped value being written
        logic [BIC_W-1:0] bic;      // clamped value in effect
    } t_cfg_ctl;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] block_index;
        t_status          status;
        logic [CNT_W-1:0] alloc_requests;
        logic [CNT_W-1:0] free_list_hits;
        logic [CNT_W-1:0] bump_hits;
        logic [4:0]       chunks_open;
    } t_result;

    // A value of zero counts as one block; values above the chunk stride
    // are limited to the stride.
    function automatic logic [BIC_W-1:0] clamp_blocks(input logic [BIC_W-1:0] v,
                                                      input int unsigned maxb);
        logic [BIC_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = 9'd1;
        end else if (32'(v) > maxb) begin
            res = BIC_W'(maxb);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/fbpa_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fbpa_link_ram
// Link memory of the free list: one write port, one registered read port.
// ============================================================================
module fbpa_link_ram
    import fbpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_link_wr    i_wr,
    input  wire t_link_rd    i_rd,
    output t_link_entry      o_rdata
);

    t_link_entry r_mem [LINK_DEPTH];
    t_link_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/fbpa_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fbpa_cfg_regs
// APB-style register port holding blocks_in_chunk.
// ============================================================================
module fbpa_cfg_regs
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS_PER_CHUNK = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg_ctl         o_cfg
);

    logic [BIC_W-1:0] r_bic_raw;
    logic [BIC_W-1:0] n_bic_raw;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_BLOCKS_IN_CHUNK);

    assign n_bic_raw = wr_hit ? pwdata[BIC_W-1:0] : r_bic_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bic_raw <= BIC_RESET_RAW;
        end else begin
            r_bic_raw <= n_bic_raw;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BLOCKS_IN_CHUNK) begin
            prdata = 32'(r_bic_raw);
        end
    end

    assign o_cfg.reinit   = wr_hit;
    assign o_cfg.bic_next = clamp_blocks(pwdata[BIC_W-1:0], MAX_BLOCKS_PER_CHUNK);
    assign o_cfg.bic      = clamp_blocks(r_bic_raw, MAX_BLOCKS_PER_CHUNK);

endmodule
`default_nettype wire

### rtl/fbpa_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fbpa_core
// Allocation sequencer: free list pop and push, bump pointer, chunk growth.
// ============================================================================
module fbpa_core
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS           = 16,
    parameter int unsigned MAX_BLOCKS_PER_CHUNK = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_operation,
    input  wire logic [IDX_W-1:0] i_block_to_free,
    input  wire t_cfg_ctl         i_cfg,
    input  wire t_link_entry      i_link_rdata,
    output logic                  o_busy,
    output t_link_rd              o_link_rd,
    output t_link_wr              o_link_wr,
    output t_result               o_result
);

    localparam int CC_W = $clog2(MAX_CHUNKS + 1);
    localparam logic [CC_W-1:0] CC_MAX = CC_W'(MAX_CHUNKS);
    localparam logic [CC_W-1:0] CC_ONE = CC_W'(1);
    localparam logic [BIC_W-1:0] BIC_RESET = clamp_blocks(BIC_RESET_RAW, MAX_BLOCKS_PER_CHUNK);
    localparam logic [IDX_W-1:0] CHUNK_STEP = IDX_W'(MAX_BLOCKS_PER_CHUNK % LINK_DEPTH);
    localparam logic [BIC_W-1:0] BIC_ONE = BIC_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Chunk number of a block by reciprocal multiplication, exact for 12-bit indices.
    localparam int DIV_SH = IDX_W + $clog2(MAX_BLOCKS_PER_CHUNK);
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SH) + 64'(MAX_BLOCKS_PER_CHUNK) - 64'd1) / 64'(MAX_BLOCKS_PER_CHUNK);
    localparam logic [13:0] RECIP = 14'(RECIP_L);
    localparam logic [31:0] STRIDE = 32'(MAX_BLOCKS_PER_CHUNK);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic             r_nonempty, n_nonempty;
    logic [BIC_W-1:0] r_bump, n_bump;
    logic [CC_W-1:0]  r_cc, n_cc;
    logic [IDX_W-1:0] r_base, n_base;
    logic [CNT_W-1:0] r_req_cnt, n_req_cnt;
    logic [CNT_W-1:0] r_hit_cnt, n_hit_cnt;
    logic [CNT_W-1:0] r_bump_cnt, n_bump_cnt;
    logic             r_done, n_done;
    logic [IDX_W-1:0] r_index, n_index;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_blk, n_blk;
    logic [IDX_W-1:0] r_quo, n_quo;

    logic             accept;
    logic [25:0]      quo_prod;
    logic [IDX_W-1:0] slot_off;
    logic [IDX_W-1:0] slot;
    logic             free_ok;
    logic [31:0]      cc_ext;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    assign quo_prod = 26'(i_block_to_free) * 26'(RECIP);
    assign slot_off = IDX_W'(32'(r_quo) * STRIDE);
    assign slot     = r_blk - slot_off;
    assign free_ok  = (32'(r_quo) < 32'(r_cc)) && (slot < IDX_W'(i_cfg.bic));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_FREE) begin
                        n_state = S_FREE;
                    end else if (r_nonempty) begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP:   n_state = S_IDLE;
            S_FREE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head     = r_head;
        n_nonempty = r_nonempty;
        n_bump     = r_bump;
        n_cc       = r_cc;
        n_base     = r_base;
        n_req_cnt  = r_req_cnt;
        n_hit_cnt  = r_hit_cnt;
        n_bump_cnt = r_bump_cnt;
        n_done     = 1'b0;
        n_index    = '0;
        n_status   = r_status;
        n_blk      = r_blk;
        n_quo      = r_quo;
        o_link_rd.en    = 1'b0;
        o_link_rd.addr  = r_head;
        o_link_wr.en    = 1'b0;
        o_link_wr.addr  = r_blk;
        o_link_wr.data.last = !r_nonempty;
        o_link_wr.data.next = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_ALLOC) begin
                        n_req_cnt = r_req_cnt + CNT_ONE;
                        if (r_nonempty) begin
                            o_link_rd.en = 1'b1;
                        end else if (r_bump != '0) begin
                            n_bump     = r_bump - BIC_ONE;
                            n_bump_cnt = r_bump_cnt + CNT_ONE;
                            n_index    = r_base + IDX_W'(n_bump);
                            n_status   = ST_BUMP;
                            n_done     = 1'b1;
                        end else if (r_cc < CC_MAX) begin
                            n_cc     = r_cc + CC_ONE;
                            n_base   = r_base + CHUNK_STEP;
                            n_bump   = i_cfg.bic - BIC_ONE;
                            n_index  = n_base + IDX_W'(n_bump);
                            n_status = ST_NEW_CHUNK;
                            n_done   = 1'b1;
                        end else begin
                            n_status = ST_EXHAUSTED;
                            n_done   = 1'b1;
                        end
                    end else begin
                        n_blk = i_block_to_free;
                        n_quo = IDX_W'(quo_prod >> DIV_SH);
                    end
                end
            end
            S_POP: begin
                n_index    = r_head;
                n_head     = i_link_rdata.next;
                n_nonempty = !i_link_rdata.last;
                n_hit_cnt  = r_hit_cnt + CNT_ONE;
                n_status   = ST_LIST_HIT;
                n_done     = 1'b1;
            end
            S_FREE: begin
                n_done = 1'b1;
                if (free_ok) begin
                    o_link_wr.en = 1'b1;
                    n_head       = r_blk;
                    n_nonempty   = 1'b1;
                    n_status     = ST_FREE_DONE;
                end else begin
                    n_status = ST_FREE_REJECT;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase

        // A register write starts the pool over with one full chunk.
        if (i_cfg.reinit) begin
            n_head     = '0;
            n_nonempty = 1'b0;
            n_bump     = i_cfg.bic_next;
            n_cc       = CC_ONE;
            n_base     = '0;
            n_req_cnt  = '0;
            n_hit_cnt  = '0;
            n_bump_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_nonempty <= 1'b0;
            r_bump     <= BIC_RESET;
            r_cc       <= CC_ONE;
            r_base     <= '0;
            r_req_cnt  <= '0;
            r_hit_cnt  <= '0;
            r_bump_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            r_bump     <= n_bump;
            r_cc       <= n_cc;
            r_base     <= n_base;
            r_req_cnt  <= n_req_cnt;
            r_hit_cnt  <= n_hit_cnt;
            r_bump_cnt <= n_bump_cnt;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index  <= n_index;
        r_status <= n_status;
        r_blk    <= n_blk;
        r_quo    <= n_quo;
    end

    assign cc_ext = 32'(r_cc);

    assign o_result.done           = r_done;
    assign o_result.block_index    = r_index;
    assign o_result.status         = r_status;
    assign o_result.alloc_requests = r_req_cnt;
    assign o_result.free_list_hits = r_hit_cnt;
    assign o_result.bump_hits      = r_bump_cnt;
    assign o_result.chunks_open    = 5'(cc_ext);

    // A pop only follows a link read issued while the list held blocks.
    a_pop_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_link_rd.en |=> (r_state == S_POP))
        else $error("link read not followed by pop");

    a_pop_needs_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(r_nonempty))
        else $error("pop with empty free list");

    // Every accepted request is either decided or still in flight in the next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_done || (r_state != S_IDLE)))
        else $error("accepted request lost");

    a_chunk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cc >= CC_ONE) && (r_cc <= CC_MAX) && (r_bump <= i_cfg.bic))
        else $error("chunk count or bump slot out of range");

    // The link memory is written only by an accepted push.
    a_write_is_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_link_wr.en |=> (r_done && (r_status == ST_FREE_DONE) && r_nonempty))
        else $error("link write without a completed free");

endmodule
`default_nettype wire

### rtl/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fixed_block_pool_allocator
// Fixed-size block allocator with a LIFO free list and chunked bump pointer.
// ============================================================================
//
//  Channel   Handshake                      Payload
//  -------   -----------------------------  ---------------------------------
//  request   start high while busy is low   i_operation, i_block_to_free
//  result    o_done strobe, one cycle       o_block_index, o_status, counters
//  config    psel & penable & pwrite        paddr, pwdata (prdata on read)
//
// An allocate served by the bump pointer, by a new chunk or reported as
// exhausted is decided at once; busy stays low and the next word can follow
// in the very next cycle. An allocate from the free list first issues a
// registered read of the link memory at the list head, then pops it in S_POP.
// A free first registers the chunk number of the block from a reciprocal
// multiply, then does the ownership check and the push in S_FREE.
// Each result word appears on the o_done cycle after the decision; the
// receiver cannot stall it, and the block accepts a new word meanwhile.
// Reset is synchronous: the pool comes up with one open, full chunk of
// 256 blocks (or the chunk stride, if smaller) and an empty free list.
// The link memory is not cleared; entries are only read after a push.
//
// Blocks are numbered chunk * MAX_BLOCKS_PER_CHUNK + slot, kept to 12 bits.
// Writing blocks_in_chunk (byte address 0) reinitializes the pool; a value
// of zero counts as one and values above the stride are limited to it.
// ============================================================================
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS           = 16,
    parameter int unsigned MAX_BLOCKS_PER_CHUNK = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request port
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_operation,
    input  wire logic [11:0] i_block_to_free,
    // Result port
    output logic             o_done,
    output logic [11:0]      o_block_index,
    output logic [2:0]       o_status,
    output logic [31:0]      o_alloc_requests,
    output logic [31:0]      o_free_list_hits,
    output logic [31:0]      o_bump_hits,
    output logic [4:0]       o_chunks_open,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg_ctl    cfg;
    t_link_rd    link_rd;
    t_link_wr    link_wr;
    t_link_entry link_rdata;
    t_result     result;

    // The register block supplies the clamped chunk size and a restart pulse.
    fbpa_cfg_regs #(
        .MAX_BLOCKS_PER_CHUNK(MAX_BLOCKS_PER_CHUNK)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The sequencer owns the list head, bump pointer, chunk count and counters.
    fbpa_core #(
        .MAX_CHUNKS          (MAX_CHUNKS),
        .MAX_BLOCKS_PER_CHUNK(MAX_BLOCKS_PER_CHUNK)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_operation    (i_operation),
        .i_block_to_free(i_block_to_free),
        .i_cfg          (cfg),
        .i_link_rdata   (link_rdata),
        .o_busy         (busy),
        .o_link_rd      (link_rd),
        .o_link_wr      (link_wr),
        .o_result       (result)
    );

    // Each block's entry holds the next block down the free list.
    fbpa_link_ram u_link (
        .i_clk  (i_clk),
        .i_wr   (link_wr),
        .i_rd   (link_rd),
        .o_rdata(link_rdata)
    );

    assign o_done           = result.done;
    assign o_block_index    = result.block_index;
    assign o_status         = result.status;
    assign o_alloc_requests = result.alloc_requests;
    assign o_free_list_hits = result.free_list_hits;
    assign o_bump_hits      = result.bump_hits;
    assign o_chunks_open    = result.chunks_open;

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench of the fixed block pool allocator: it mirrors the pool
// (free list, bump slot, chunk count and counters), predicts every result
// word and compares it field by field while requests are driven in order.
// ============================================================================
module tb;
    import fbpa_pkg::*;

    // The bench is written for the default geometry of the block.
    localparam int CHUNK_LIMIT  = 16;
    localparam int STRIDE       = 256;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;

    // Byte address of blocks_in_chunk: register index times four.
    localparam logic [2:0] ADDR_BLOCKS_IN_CHUNK = {REG_BLOCKS_IN_CHUNK, 2'b00};

    // One predicted result word.
    typedef struct {
        logic [IDX_W-1:0] block_index;
        t_status          status;
        logic [CNT_W-1:0] alloc_requests;
        logic [CNT_W-1:0] free_list_hits;
        logic [CNT_W-1:0] bump_hits;
        logic [4:0]       chunks_open;
    } t_pool_outcome;

    // All inputs start at a known value; reset is held from time zero.
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              start           = 1'b0;
    logic              i_operation     = OP_ALLOC;
    logic [IDX_W-1:0]  i_block_to_free = '0;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [2:0]        paddr           = '0;
    logic [31:0]       pwdata          = '0;

    logic              busy;
    logic              o_done;
    logic [IDX_W-1:0]  o_block_index;
    logic [2:0]        o_status;
    logic [31:0]       o_alloc_requests;
    logic [31:0]       o_free_list_hits;
    logic [31:0]       o_bump_hits;
    logic [4:0]        o_chunks_open;
    logic [31:0]       prdata;
    logic              pready;

    fixed_block_pool_allocator #(
        .MAX_CHUNKS           (CHUNK_LIMIT),
        .MAX_BLOCKS_PER_CHUNK (STRIDE)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_block_to_free  (i_block_to_free),
        .o_done           (o_done),
        .o_block_index    (o_block_index),
        .o_status         (o_status),
        .o_alloc_requests (o_alloc_requests),
        .o_free_list_hits (o_free_list_hits),
        .o_bump_hits      (o_bump_hits),
        .o_chunks_open    (o_chunks_open),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Mirror of the pool. The link entries are only read after a free has
    // written them, exactly like the block itself.
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0] link_next [LINK_DEPTH];
    logic             link_last [LINK_DEPTH];
    int               pool_bic;
    logic [IDX_W-1:0] pool_head;
    logic             pool_list_busy;
    int               pool_bump_slot;
    int               pool_chunks;
    logic [CNT_W-1:0] pool_requests;
    logic [CNT_W-1:0] pool_list_hits;
    logic [CNT_W-1:0] pool_bumps;

    t_pool_outcome    awaited_outcomes [$];
    // Blocks handed out and not yet returned; used to build sensible frees.
    logic [IDX_W-1:0] live_blocks [$];

    int               fail_count  = 0;
    int               cycle_count = 0;
    int               idle_pct    = 0;

    // Empty free list, one full chunk, counters cleared.
    task automatic pool_reinit();
        pool_head      = '0;
        pool_list_busy = 1'b0;
        pool_bump_slot = pool_bic;
        pool_chunks    = 1;
        pool_requests  = '0;
        pool_list_hits = '0;
        pool_bumps     = '0;
        live_blocks.delete();
    endtask

    // Apply one request to the mirror and return the word it must produce.
    task automatic predict_pool_op(input logic op, input logic [IDX_W-1:0] blk,
                                   output t_pool_outcome res);
        logic [IDX_W-1:0] popped;
        res.block_index = '0;
        if (op == OP_ALLOC) begin
            pool_requests = pool_requests + 1;
            if (pool_list_busy) begin
                // Pop the head of the LIFO free list.
                popped          = pool_head;
                pool_list_hits  = pool_list_hits + 1;
                res.block_index = popped;
                pool_head       = link_next[popped];
                pool_list_busy  = !link_last[popped];
                res.status      = ST_LIST_HIT;
            end else if (pool_bump_slot > 0) begin
                pool_bumps      = pool_bumps + 1;
                pool_bump_slot  = pool_bump_slot - 1;
                res.block_index = IDX_W'((pool_chunks - 1) * STRIDE + pool_bump_slot);
                res.status      = ST_BUMP;
            end else if (pool_chunks < CHUNK_LIMIT) begin
                // Open a new chunk and hand out its top slot.
                pool_chunks     = pool_chunks + 1;
                pool_bump_slot  = pool_bic - 1;
                res.block_index = IDX_W'((pool_chunks - 1) * STRIDE + pool_bump_slot);
                res.status      = ST_NEW_CHUNK;
            end else begin
                res.status = ST_EXHAUSTED;
            end
        end else begin
            // A free is only taken for a block inside an opened chunk and below the chunk size.
            if ((int'(blk) / STRIDE) < pool_chunks && (int'(blk) % STRIDE) < pool_bic) begin
                link_next[blk] = pool_head;
                link_last[blk] = !pool_list_busy;
                pool_head      = blk;
                pool_list_busy = 1'b1;
                res.status     = ST_FREE_DONE;
            end else begin
                res.status = ST_FREE_REJECT;
            end
        end
        res.alloc_requests = pool_requests;
        res.free_list_hits = pool_list_hits;
        res.bump_hits      = pool_bumps;
        res.chunks_open    = 5'(pool_chunks);
    endtask

    // ------------------------------------------------------------------------
    // Result checking and request capture. Both look at values from before
    // the edge, so the order of processes in a time step does not matter.
    // A result word can never come out at the edge that accepts its request,
    // so checking first and predicting second is safe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pool_outcome want;
        t_pool_outcome got;
        if (i_rst_n) begin
            if (o_done) begin
                if (awaited_outcomes.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected result word: idx=%0d status=%0d",
                                 o_block_index, o_status);
                    end
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (o_block_index !== want.block_index || o_status !== want.status ||
                        o_alloc_requests !== want.alloc_requests ||
                        o_free_list_hits !== want.free_list_hits ||
                        o_bump_hits !== want.bump_hits ||
                        o_chunks_open !== want.chunks_open) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("mismatch exp: idx=%0d st=%0d req=%0d lh=%0d bh=%0d ch=%0d",
                                     want.block_index, want.status, want.alloc_requests,
                                     want.free_list_hits, want.bump_hits, want.chunks_open);
                            $display("         got: idx=%0d st=%0d req=%0d lh=%0d bh=%0d ch=%0d",
                                     o_block_index, o_status, o_alloc_requests,
                                     o_free_list_hits, o_bump_hits, o_chunks_open);
                        end
                    end
                end
            end
            if (start && !busy) begin
                predict_pool_op(i_operation, i_block_to_free, got);
                awaited_outcomes.push_back(got);
                if (i_operation == OP_ALLOC && (got.status == ST_LIST_HIT ||
                    got.status == ST_BUMP || got.status == ST_NEW_CHUNK)) begin
                    live_blocks.push_back(got.block_index);
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result word ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving. A request stays on the port until it is accepted; start is
    // left high when the next word follows at once, so it never gets two
    // assignments in one time step.
    // ------------------------------------------------------------------------
    task automatic issue_request(input logic op, input logic [IDX_W-1:0] blk);
        while ($urandom_range(99) < idle_pct) begin
            start           <= 1'b0;
            i_operation     <= 1'($urandom);
            i_block_to_free <= IDX_W'($urandom);
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_operation     <= op;
        i_block_to_free <= blk;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    // Hold off new requests until every predicted word has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (awaited_outcomes.size() != 0);
    endtask

    // Register writes only happen on a quiet block, and they reset the
    // mirror the same way the block reinitializes its pool.
    task automatic write_blocks_in_chunk(input logic [31:0] value);
        int v;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_BLOCKS_IN_CHUNK;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        v = int'(value[BIC_W-1:0]);
        if (v == 0) begin
            v = 1;
        end else if (v > STRIDE) begin
            v = STRIDE;
        end
        pool_bic = v;
        pool_reinit();
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Pool as it comes out of reset: bump allocation from the top slot,
    // list pops in LIFO order, a double free, and frees outside the pool.
    task automatic test_reset_pool();
        issue_request(OP_ALLOC, '0);
        issue_request(OP_ALLOC, 12'hFFF);       // block field ignored
        issue_request(OP_FREE, 12'd255);
        issue_request(OP_FREE, 12'd0);
        issue_request(OP_FREE, 12'd0);          // double free is pushed again
        issue_request(OP_ALLOC, '0);
        issue_request(OP_ALLOC, '0);
        issue_request(OP_ALLOC, '0);
        issue_request(OP_FREE, 12'h100);        // chunk one is not open yet
        issue_request(OP_FREE, 12'hFFF);
    endtask

    // One block per chunk: every further allocate opens a chunk until the
    // chunk cap is reached, then the pool reports exhausted.
    task automatic test_exhaustion();
        write_blocks_in_chunk(32'd0);           // zero counts as one block
        repeat (CHUNK_LIMIT + 1) issue_request(OP_ALLOC, '0);
        issue_request(OP_FREE, 12'hF01);        // slot beyond the chunk size
        issue_request(OP_FREE, 12'hF00);
        issue_request(OP_ALLOC, '0);
    endtask

    // Mostly well-formed traffic: frees of blocks that are really out,
    // some frees of any in-pool block (double frees among them) and some
    // raw noise that is usually rejected.
    task automatic test_random_traffic(input logic [31:0] bic_word, input int count);
        int               pick;
        int               sel;
        logic [IDX_W-1:0] blk;
        write_blocks_in_chunk(bic_word);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(39) == 0) begin
                wait_for_results();
            end
            if ($urandom_range(99) < 55) begin
                issue_request(OP_ALLOC, IDX_W'($urandom));
            end else begin
                sel = $urandom_range(99);
                if (sel < 55 && live_blocks.size() != 0) begin
                    pick = $urandom_range(live_blocks.size() - 1);
                    blk  = live_blocks[pick];
                    live_blocks.delete(pick);
                end else if (sel < 70) begin
                    blk = IDX_W'($urandom_range(pool_chunks - 1) * STRIDE +
                                 $urandom_range(pool_bic - 1));
                end else begin
                    blk = IDX_W'($urandom);
                end
                issue_request(OP_FREE, blk);
            end
        end
    endtask

    initial begin
        pool_bic = STRIDE;
        pool_reinit();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 21;
        test_reset_pool();
        test_exhaustion();
        test_random_traffic(32'd3, 90);
        test_random_traffic(32'd511, 60);      // above the stride, limited

        idle_pct = 64;
        test_random_traffic(32'd1, 90);
        test_random_traffic(32'hFFFF_FE05, 70); // only the low nine bits count

        idle_pct = 0;
        test_random_traffic(32'd256, 60);
        test_random_traffic(32'($urandom_range(12, 4)), 90);
        test_random_traffic(32'd2, 40);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/fbpa_pkg.sv
rtl/fbpa_link_ram.sv
rtl/fbpa_cfg_regs.sv
rtl/fbpa_core.sv
rtl/fixed_block_pool_allocator.sv
dv/tb.sv
